// ===== rtl/rrs_pkg.sv =====
package rrs_pkg;

    localparam int unsigned IN_DATA_W  = 160;
    localparam int unsigned OUT_DATA_W = 224;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned FRAC_W     = 8;
    localparam int unsigned DIV_CNT_W  = 4;
    localparam int unsigned NUM_W      = 40;

    localparam logic [31:0] REPORT_INTERVAL_RESET = 32'd65536;
    localparam logic [1:0]  RTP_VERSION           = 2'd2;
    localparam logic [7:0]  PT_SR_MUXED           = 8'd200;
    localparam logic [7:0]  PT_RR_MUXED           = 8'd201;
    localparam logic [15:0] REORDER_WINDOW        = 16'd32768;
    localparam logic [23:0] CUM_LOST_MAX          = 24'hFFFFFF;
    localparam logic [FRAC_W-1:0] FRAC_MAX        = 8'd255;

    localparam logic [KIND_W-1:0] REQ_RTP      = 3'd0;
    localparam logic [KIND_W-1:0] REQ_RR       = 3'd1;
    localparam logic [KIND_W-1:0] REQ_SR       = 3'd2;
    localparam logic [KIND_W-1:0] REQ_TICK     = 3'd3;
    localparam logic [KIND_W-1:0] REQ_BITRATE  = 3'd4;
    localparam logic [KIND_W-1:0] REQ_KEYFRAME = 3'd5;

    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FWD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMB   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REPORT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PLI    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_PREP,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic check;
        logic prep;
        logic div_step;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic report_ok;
        logic div_last;
    } status_t;

endpackage

// ===== rtl/rrs_ctrl.sv =====
module rrs_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  rrs_pkg::status_t status,
    output rrs_pkg::cmd_t    cmd
);

    rrs_pkg::state_t state_reg;
    rrs_pkg::state_t state_next;
    logic            m_tvalid_reg;
    logic            m_tvalid_next;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = rrs_pkg::ST_EXEC;
                end
            end
            rrs_pkg::ST_EXEC:
            begin
                state_next = status.is_tick ? rrs_pkg::ST_CHECK : rrs_pkg::ST_LOAD;
            end
            rrs_pkg::ST_CHECK:
            begin
                state_next = status.report_ok ? rrs_pkg::ST_PREP : rrs_pkg::ST_LOAD;
            end
            rrs_pkg::ST_PREP:
            begin
                state_next = rrs_pkg::ST_DIV;
            end
            rrs_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = rrs_pkg::ST_LOAD;
                end
            end
            rrs_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = rrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            rrs_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            rrs_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            rrs_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            rrs_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            rrs_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            rrs_pkg::ST_LOAD:
            begin
                cmd.load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rrs_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== rtl/rrs_datapath.sv =====
module rrs_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rrs_pkg::cmd_t                       cmd,
    output rrs_pkg::status_t                    status,
    input  logic [rrs_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic [rrs_pkg::KIND_W-1:0]          s_tuser,
    input  logic [31:0]                         report_interval,
    output logic [rrs_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [rrs_pkg::KIND_W-1:0]          m_tuser
);

    logic [rrs_pkg::KIND_W-1:0] req_reg;
    logic                       short_reg;
    logic [1:0]                 ver_reg;
    logic [7:0]                 pt_reg;
    logic [31:0]                ssrc_in_reg;
    logic [15:0]                seq_in_reg;
    logic [63:0]                ntp_in_reg;
    logic [31:0]                rate_in_reg;

    logic        have_packets_reg;
    logic [15:0] last_seq_reg;
    logic [15:0] base_seq_reg;
    logic [15:0] wrap_count_reg;
    logic [31:0] lost_total_reg;
    logic [31:0] prev_lost_reg;
    logic [31:0] prev_expected_reg;
    logic [31:0] cur_ssrc_reg;
    logic [63:0] sr_ntp_reg;
    logic [31:0] sr_tick_reg;
    logic [31:0] report_tick_reg;
    logic [31:0] now_tick_reg;
    logic [31:0] bitrate_set_reg;

    logic [rrs_pkg::KIND_W-1:0] res_kind_reg;
    logic [31:0]                res_ssrc_reg;
    logic [31:0]                res_bitrate_reg;
    logic [15:0]                res_hseq_reg;
    logic [15:0]                res_cycles_reg;
    logic [rrs_pkg::FRAC_W-1:0] res_frac_reg;
    logic [23:0]                res_cum_reg;
    logic [63:0]                res_ntp_reg;
    logic [31:0]                res_delay_reg;

    logic [31:0]                 expected_reg;
    logic [31:0]                 dloss_reg;
    logic [rrs_pkg::NUM_W-1:0]   rem_reg;
    logic [rrs_pkg::NUM_W-1:0]   dvs_reg;
    logic [rrs_pkg::FRAC_W-1:0]  quo_reg;
    logic [rrs_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic                        sat_reg;
    logic                        frac_zero_reg;

    logic        rtp_ok;
    logic        seq_back;
    logic        seq_wrap;
    logic [31:0] lost_delta;
    logic [31:0] elapsed;
    logic [31:0] dexp;
    logic [rrs_pkg::NUM_W-1:0] num;
    logic        div_ge;
    logic [rrs_pkg::FRAC_W-1:0] quo_next;
    logic [23:0] cum_clamped;

    assign rtp_ok = !short_reg && (ver_reg == rrs_pkg::RTP_VERSION)
                    && (pt_reg != rrs_pkg::PT_SR_MUXED) && (pt_reg != rrs_pkg::PT_RR_MUXED);
    assign seq_back = seq_in_reg < last_seq_reg;
    assign seq_wrap = seq_back && ((last_seq_reg - seq_in_reg) > rrs_pkg::REORDER_WINDOW);
    assign lost_delta = {16'd0, seq_in_reg} - {16'd0, last_seq_reg} - 32'd1
                        + {15'd0, seq_wrap, 16'd0};

    assign elapsed = now_tick_reg - report_tick_reg;
    assign dexp    = expected_reg - prev_expected_reg;
    assign num     = {dloss_reg, 8'd0} - {8'd0, dloss_reg};
    assign div_ge  = rem_reg >= dvs_reg;
    assign quo_next = {quo_reg[rrs_pkg::FRAC_W-2:0], div_ge};

    always_comb
    begin
        if (lost_total_reg[31])
        begin
            cum_clamped = 24'd0;
        end
        else if (lost_total_reg[30:24] != 7'd0)
        begin
            cum_clamped = rrs_pkg::CUM_LOST_MAX;
        end
        else
        begin
            cum_clamped = lost_total_reg[23:0];
        end
    end

    assign status.is_tick   = req_reg == rrs_pkg::REQ_TICK;
    assign status.report_ok = have_packets_reg && (elapsed >= report_interval);
    assign status.div_last  = div_cnt_reg == '0;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg     <= s_tuser;
            short_reg   <= s_tdata[0];
            ver_reg     <= s_tdata[2:1];
            pt_reg      <= s_tdata[10:3];
            ssrc_in_reg <= s_tdata[42:11];
            seq_in_reg  <= s_tdata[58:43];
            ntp_in_reg  <= s_tdata[122:59];
            rate_in_reg <= s_tdata[154:123];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_packets_reg  <= 1'b0;
            last_seq_reg      <= '0;
            base_seq_reg      <= '0;
            wrap_count_reg    <= '0;
            lost_total_reg    <= '0;
            prev_lost_reg     <= '0;
            prev_expected_reg <= '0;
            cur_ssrc_reg      <= '0;
            sr_ntp_reg        <= '0;
            sr_tick_reg       <= '0;
            report_tick_reg   <= '0;
            now_tick_reg      <= '0;
            bitrate_set_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            case (req_reg)
                rrs_pkg::REQ_RTP:
                begin
                    if (rtp_ok)
                    begin
                        cur_ssrc_reg <= ssrc_in_reg;
                        if (!have_packets_reg)
                        begin
                            have_packets_reg <= 1'b1;
                            last_seq_reg     <= seq_in_reg;
                            base_seq_reg     <= seq_in_reg;
                        end
                        else if (!seq_back || seq_wrap)
                        begin
                            lost_total_reg <= lost_total_reg + lost_delta;
                            last_seq_reg   <= seq_in_reg;
                            if (seq_wrap)
                            begin
                                wrap_count_reg <= wrap_count_reg + 16'd1;
                            end
                        end
                    end
                end
                rrs_pkg::REQ_RR:
                begin
                    cur_ssrc_reg <= ssrc_in_reg;
                end
                rrs_pkg::REQ_SR:
                begin
                    cur_ssrc_reg <= ssrc_in_reg;
                    sr_ntp_reg   <= ntp_in_reg;
                    sr_tick_reg  <= now_tick_reg;
                end
                rrs_pkg::REQ_TICK:
                begin
                    now_tick_reg <= now_tick_reg + 32'd1;
                end
                rrs_pkg::REQ_BITRATE:
                begin
                    bitrate_set_reg <= rate_in_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.check && status.report_ok)
        begin
            prev_lost_reg   <= lost_total_reg;
            report_tick_reg <= now_tick_reg;
        end
        else if (cmd.prep)
        begin
            prev_expected_reg <= expected_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_kind_reg    <= rrs_pkg::KIND_NONE;
            res_ssrc_reg    <= '0;
            res_bitrate_reg <= '0;
            res_hseq_reg    <= '0;
            res_cycles_reg  <= '0;
            res_frac_reg    <= '0;
            res_cum_reg     <= '0;
            res_ntp_reg     <= '0;
            res_delay_reg   <= '0;
            case (req_reg)
                rrs_pkg::REQ_RTP:
                begin
                    if (rtp_ok)
                    begin
                        res_kind_reg <= rrs_pkg::KIND_FWD;
                        res_ssrc_reg <= ssrc_in_reg;
                    end
                end
                rrs_pkg::REQ_SR:
                begin
                    if (bitrate_set_reg != 32'd0)
                    begin
                        res_kind_reg    <= rrs_pkg::KIND_REMB;
                        res_ssrc_reg    <= ssrc_in_reg;
                        res_bitrate_reg <= bitrate_set_reg;
                    end
                end
                rrs_pkg::REQ_BITRATE:
                begin
                    res_kind_reg    <= rrs_pkg::KIND_REMB;
                    res_ssrc_reg    <= cur_ssrc_reg;
                    res_bitrate_reg <= rate_in_reg;
                end
                rrs_pkg::REQ_KEYFRAME:
                begin
                    res_kind_reg <= rrs_pkg::KIND_PLI;
                    res_ssrc_reg <= cur_ssrc_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.check && status.report_ok)
        begin
            res_kind_reg   <= rrs_pkg::KIND_REPORT;
            res_ssrc_reg   <= cur_ssrc_reg;
            res_hseq_reg   <= last_seq_reg;
            res_cycles_reg <= wrap_count_reg;
            res_cum_reg    <= cum_clamped;
            res_ntp_reg    <= sr_ntp_reg;
            res_delay_reg  <= now_tick_reg - sr_tick_reg;
            expected_reg   <= {wrap_count_reg, last_seq_reg} - {16'd0, base_seq_reg} + 32'd1;
            dloss_reg      <= lost_total_reg - prev_lost_reg;
        end
        else if (cmd.prep)
        begin
            frac_zero_reg <= (expected_reg == prev_expected_reg) || dloss_reg[31]
                             || (dloss_reg == 32'd0);
            rem_reg       <= num;
            dvs_reg       <= {dexp, 8'd0};
            quo_reg       <= '0;
            sat_reg       <= 1'b0;
            div_cnt_reg   <= rrs_pkg::DIV_CNT_W'(rrs_pkg::FRAC_W);
        end
        else if (cmd.div_step)
        begin
            // The first step only tests whether the quotient reaches 256.
            if (div_cnt_reg == rrs_pkg::DIV_CNT_W'(rrs_pkg::FRAC_W))
            begin
                sat_reg <= div_ge;
            end
            else
            begin
                quo_reg <= quo_next;
                if (div_ge)
                begin
                    rem_reg <= rem_reg - dvs_reg;
                end
            end
            dvs_reg     <= dvs_reg >> 1;
            div_cnt_reg <= div_cnt_reg - rrs_pkg::DIV_CNT_W'(1);
            if (div_cnt_reg == '0)
            begin
                if (frac_zero_reg)
                begin
                    res_frac_reg <= '0;
                end
                else if (sat_reg)
                begin
                    res_frac_reg <= rrs_pkg::FRAC_MAX;
                end
                else
                begin
                    res_frac_reg <= quo_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_tuser <= res_kind_reg;
            m_tdata <= {res_delay_reg, res_ntp_reg, res_cum_reg, res_frac_reg,
                        res_cycles_reg, res_hseq_reg, res_bitrate_reg, res_ssrc_reg};
        end
    end

endmodule

// ===== rtl/rtp_receiver_statistics.sv =====
// RTP receiver statistics. One input word is one parsed event: an RTP
// header, an RTCP RR or SR header, a tick, a bitrate request or a keyframe
// request, selected by s_tuser. Every accepted word gives exactly one output
// word whose m_tuser is the result kind (nothing, forward, REMB, receiver
// report or PLI); kind zero words are delivered too.
// Words are handled one at a time. After acceptance an ordinary event goes
// through EXEC and LOAD, a tick without a report through EXEC, CHECK and LOAD,
// and a tick that emits a receiver report also through PREP and the 9-step
// loss-fraction divider before LOAD. The output word is registered in LOAD.
// The result sits in an output register, so a stalled m_tready holds it there
// while the next word is already accepted and processed; the block then
// waits with s_tready low until the output register is free.
// Reset clears all statistics and sets report_interval to 65536 ticks.
// report_interval is written through the APB port at address 0. The user must
// write it only while the block is idle; the block itself does not enforce this.
module rtp_receiver_statistics
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // too_short, rtp_version, payload_type, sender_ssrc, seq_num, ntp_time,
    // bitrate_req, zero fill
    input  logic [rrs_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [rrs_pkg::KIND_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_ssrc, out_bitrate, highest_seq, seq_cycles, fraction_lost,
    // cumulative_lost, last_sr_ntp, sr_delay
    output logic [rrs_pkg::OUT_DATA_W-1:0] m_tdata,
    // result_kind
    output logic [rrs_pkg::KIND_W-1:0]     m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    rrs_pkg::cmd_t    cmd;
    rrs_pkg::status_t status;
    logic [31:0]      report_interval_reg;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = !paddr[2];
    assign prdata  = reg_sel ? report_interval_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_interval_reg <= rrs_pkg::REPORT_INTERVAL_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            report_interval_reg <= pwdata;
        end
    end

    rrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rrs_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .report_interval (report_interval_reg),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule

// ===== rtl/rrs_checker.sv =====
module rrs_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rrs_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [rrs_pkg::KIND_W-1:0]     m_tuser
);

    // A word is processed one at a time, so acceptance never repeats at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted in two consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != rrs_pkg::KIND_REPORT) |-> m_tdata[223:64] == '0)
    else $error("report fields set outside a receiver report");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == rrs_pkg::KIND_NONE) |-> m_tdata[63:0] == '0)
    else $error("empty result carries an ssrc or bitrate");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == rrs_pkg::KIND_REPORT) |-> m_tdata[63:32] == '0)
    else $error("receiver report carries a bitrate");

endmodule

bind rtp_receiver_statistics rrs_checker u_rrs_checker (.*);

// ===== sim/rtp_receiver_statistics_tb.sv =====
`timescale 1ns / 100ps

module rtp_receiver_statistics_tb;

    localparam logic [2:0] REG_REPORT_INTERVAL = 3'd0;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        bit [2:0]  req;
        bit        too_short;
        bit [1:0]  ver;
        bit [7:0]  pt;
        bit [31:0] ssrc;
        bit [15:0] seq;
        bit [63:0] ntp;
        bit [31:0] rate;
    } rtp_event_t;

    typedef struct packed {
        bit [2:0]  kind;
        bit [31:0] ssrc;
        bit [31:0] bitrate;
        bit [15:0] hseq;
        bit [15:0] cycles;
        bit [7:0]  frac;
        bit [23:0] cum;
        bit [63:0] ntp;
        bit [31:0] delay;
    } rr_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rrs_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [rrs_pkg::KIND_W-1:0]     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rrs_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [rrs_pkg::KIND_W-1:0]     m_tuser;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [2:0]                     paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    rtp_event_t event_queue[$];
    rr_result_t predicted_results[$];
    rtp_event_t bus_event;

    int  items_pushed = 0;
    int  items_accepted = 0;
    int  fail_count = 0;
    int  phase_count = 0;
    int  kind_seen[8];
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  pressure_go = 1'b0;
    logic rx_hold = 1'b0;

    bit [15:0] gen_seq = 16'd0;
    bit [31:0] gen_ssrc = 32'h1234_5678;

    bit [31:0] st_interval;
    bit        st_have;
    bit [15:0] st_last;
    bit [15:0] st_base;
    bit [15:0] st_wraps;
    bit [31:0] st_lost;
    bit [31:0] st_prev_lost;
    bit [31:0] st_prev_exp;
    bit [31:0] st_ssrc;
    bit [63:0] st_sr_ntp;
    bit [31:0] st_sr_tick;
    bit [31:0] st_report_tick;
    bit [31:0] st_now;
    bit [31:0] st_bitrate;

    string field_name[9] = '{"result_kind", "out_ssrc", "out_bitrate", "highest_seq",
                             "seq_cycles", "fraction_lost", "cumulative_lost",
                             "last_sr_ntp", "sr_delay"};

    rtp_receiver_statistics dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    function automatic rr_result_t receiver_stats_update(input rtp_event_t ev);
        rr_result_t res;
        bit [31:0]  expected;
        bit [31:0]  dexp;
        bit [31:0]  dloss;
        bit [63:0]  frac;
        res = '0;
        case (ev.req)
            rrs_pkg::REQ_RTP:
            begin
                if (!(ev.too_short || ev.ver != rrs_pkg::RTP_VERSION ||
                      ev.pt == rrs_pkg::PT_SR_MUXED || ev.pt == rrs_pkg::PT_RR_MUXED))
                begin
                    st_ssrc = ev.ssrc;
                    if (!st_have)
                    begin
                        st_have = 1'b1;
                        st_last = ev.seq;
                        st_base = ev.seq;
                    end
                    else if (ev.seq < st_last)
                    begin
                        if (({16'h0, st_last} - {16'h0, ev.seq}) >
                            {16'h0, rrs_pkg::REORDER_WINDOW})
                        begin
                            st_lost = st_lost + {16'h0, ev.seq} + 32'd65535 - {16'h0, st_last};
                            st_last = ev.seq;
                            st_wraps = st_wraps + 16'd1;
                        end
                    end
                    else
                    begin
                        st_lost = st_lost + {16'h0, ev.seq} - {16'h0, st_last} - 32'd1;
                        st_last = ev.seq;
                    end
                    res.kind = rrs_pkg::KIND_FWD;
                    res.ssrc = ev.ssrc;
                end
            end
            rrs_pkg::REQ_RR:
            begin
                st_ssrc = ev.ssrc;
            end
            rrs_pkg::REQ_SR:
            begin
                st_ssrc = ev.ssrc;
                st_sr_ntp = ev.ntp;
                st_sr_tick = st_now;
                if (st_bitrate != 32'd0)
                begin
                    res.kind = rrs_pkg::KIND_REMB;
                    res.ssrc = st_ssrc;
                    res.bitrate = st_bitrate;
                end
            end
            rrs_pkg::REQ_TICK:
            begin
                st_now = st_now + 32'd1;
                if (st_have && (st_now - st_report_tick) >= st_interval)
                begin
                    expected = {16'h0, st_last} + {st_wraps, 16'h0} - {16'h0, st_base} + 32'd1;
                    dexp = expected - st_prev_exp;
                    dloss = st_lost - st_prev_lost;
                    frac = 64'd0;
                    if (dexp != 32'd0 && !dloss[31] && dloss != 32'd0)
                    begin
                        frac = ({32'h0, dloss} * 64'd255) / {32'h0, dexp};
                        if (frac > {56'h0, rrs_pkg::FRAC_MAX})
                            frac = {56'h0, rrs_pkg::FRAC_MAX};
                    end
                    res.kind = rrs_pkg::KIND_REPORT;
                    res.ssrc = st_ssrc;
                    res.hseq = st_last;
                    res.cycles = st_wraps;
                    res.frac = frac[7:0];
                    if (st_lost[31])
                        res.cum = 24'h0;
                    else if (st_lost > {8'h0, rrs_pkg::CUM_LOST_MAX})
                        res.cum = rrs_pkg::CUM_LOST_MAX;
                    else
                        res.cum = st_lost[23:0];
                    res.ntp = st_sr_ntp;
                    res.delay = st_now - st_sr_tick;
                    st_prev_lost = st_lost;
                    st_prev_exp = expected;
                    st_report_tick = st_now;
                end
            end
            rrs_pkg::REQ_BITRATE:
            begin
                st_bitrate = ev.rate;
                res.kind = rrs_pkg::KIND_REMB;
                res.ssrc = st_ssrc;
                res.bitrate = ev.rate;
            end
            rrs_pkg::REQ_KEYFRAME:
            begin
                res.kind = rrs_pkg::KIND_PLI;
                res.ssrc = st_ssrc;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic rtp_event_t rand_fields(input bit [2:0] req);
        rtp_event_t ev;
        ev.req = req;
        ev.too_short = 1'($urandom);
        ev.ver = 2'($urandom);
        ev.pt = 8'($urandom);
        ev.ssrc = $urandom;
        ev.seq = 16'($urandom);
        ev.ntp = {$urandom, $urandom};
        ev.rate = $urandom;
        return ev;
    endfunction

    function automatic rtp_event_t good_rtp(input bit [31:0] ssrc, input bit [15:0] seq);
        rtp_event_t ev;
        ev = rand_fields(rrs_pkg::REQ_RTP);
        ev.too_short = 1'b0;
        ev.ver = rrs_pkg::RTP_VERSION;
        ev.ssrc = ssrc;
        ev.seq = seq;
        if (ev.pt == rrs_pkg::PT_SR_MUXED || ev.pt == rrs_pkg::PT_RR_MUXED)
            ev.pt = ev.pt - 8'd100;
        return ev;
    endfunction

    function automatic rtp_event_t random_event(input bit storm);
        rtp_event_t ev;
        int unsigned pick;
        int unsigned sub;
        bit [15:0]   step;
        pick = $urandom_range(99);
        if (storm)
        begin
            // Alternate between the bottom and the top of the sequence space so
            // that every forward jump adds a large loss and the total saturates.
            if (pick < 94)
            begin
                step = 16'($urandom_range(63));
                gen_seq = (gen_seq < 16'd32768) ? 16'hFFFF - step : step;
                ev = good_rtp(gen_ssrc, gen_seq);
            end
            else
                ev = rand_fields(rrs_pkg::REQ_TICK);
            return ev;
        end
        if (pick < 45)
        begin
            sub = $urandom_range(99);
            if (sub < 68)
                step = 16'd1;
            else if (sub < 78)
                step = 16'($urandom_range(20, 2));
            else if (sub < 83)
                step = 16'd0;
            else if (sub < 89)
                step = 16'd0 - 16'($urandom_range(100, 1));
            else if (sub < 94)
                step = 16'($urandom_range(32768, 100));
            else if (sub < 97)
                step = 16'($urandom);
            else
                step = 16'($urandom_range(65535, 32769));
            gen_seq = gen_seq + step;
            if ($urandom_range(15) == 0)
                gen_ssrc = $urandom;
            ev = good_rtp(gen_ssrc, gen_seq);
        end
        else if (pick < 75)
            ev = rand_fields(rrs_pkg::REQ_TICK);
        else if (pick < 80)
            ev = rand_fields(rrs_pkg::REQ_SR);
        else if (pick < 83)
            ev = rand_fields(rrs_pkg::REQ_RR);
        else if (pick < 87)
        begin
            ev = rand_fields(rrs_pkg::REQ_BITRATE);
            if ($urandom_range(3) == 0)
                ev.rate = 32'd0;
        end
        else if (pick < 90)
            ev = rand_fields(rrs_pkg::REQ_KEYFRAME);
        else if (pick < 97)
        begin
            ev = good_rtp($urandom, 16'($urandom));
            case ($urandom_range(2))
                0:
                begin
                    ev.too_short = 1'b1;
                    ev.ver = 2'($urandom);
                end
                1:
                begin
                    ev.ver = 2'($urandom_range(2));
                    if (ev.ver == rrs_pkg::RTP_VERSION)
                        ev.ver = 2'd3;
                end
                default:
                begin
                    ev.pt = $urandom_range(1) ? rrs_pkg::PT_SR_MUXED : rrs_pkg::PT_RR_MUXED;
                end
            endcase
        end
        else
            ev = rand_fields(3'($urandom_range(7, 6)));
        return ev;
    endfunction

    task automatic push_event(input rtp_event_t ev);
        event_queue.insert(event_queue.size(), ev);
        items_pushed++;
    endtask

    task automatic write_interval(input bit [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_REPORT_INTERVAL;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        st_interval = value;
    endtask

    task automatic wait_drained;
        while (items_accepted != items_pushed || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input bit [31:0] interval, input int tx_pct, input int rx_pct,
                             input int count, input bit storm, input bit pressure);
        write_interval(interval);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        phase_count++;
        if (pressure)
            pressure_go = 1'b1;
        for (int n = 0; n < count; n++)
            push_event(random_event(storm));
        wait_drained;
    endtask

    always @(posedge clk)
    begin : driver
        rtp_event_t ev;
        rr_result_t res;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                res = receiver_stats_update(bus_event);
                predicted_results.insert(predicted_results.size(), res);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (event_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    ev = event_queue.pop_front();
                    bus_event <= ev;
                    s_tvalid <= 1'b1;
                    s_tuser <= ev.req;
                    s_tdata <= {5'b0, ev.rate, ev.ntp, ev.seq, ev.ssrc, ev.pt, ev.ver,
                                ev.too_short};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        rr_result_t want;
        bit [63:0]  got_f[9];
        bit [63:0]  want_f[9];
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected output word: kind %0d data %h", m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    kind_seen[want.kind]++;
                    got_f = '{64'(m_tuser), 64'(m_tdata[31:0]), 64'(m_tdata[63:32]),
                              64'(m_tdata[79:64]), 64'(m_tdata[95:80]),
                              64'(m_tdata[103:96]), 64'(m_tdata[127:104]),
                              m_tdata[191:128], 64'(m_tdata[223:192])};
                    want_f = '{64'(want.kind), 64'(want.ssrc), 64'(want.bitrate),
                               64'(want.hseq), 64'(want.cycles), 64'(want.frac),
                               64'(want.cum), want.ntp, 64'(want.delay)};
                    for (int i = 0; i < 9; i++)
                    begin
                        if (got_f[i] !== want_f[i])
                        begin
                            if (fail_count < 10)
                                $display("Mismatch in %s at %0t: expected %0h, got %0h",
                                         field_name[i], $realtime, want_f[i], got_f[i]);
                            fail_count++;
                        end
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin : hold_off
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : stimulus
        rtp_event_t ev;
        st_interval = rrs_pkg::REPORT_INTERVAL_RESET;
        st_have = 1'b0;
        st_last = '0;
        st_base = '0;
        st_wraps = '0;
        st_lost = '0;
        st_prev_lost = '0;
        st_prev_exp = '0;
        st_ssrc = '0;
        st_sr_ntp = '0;
        st_sr_tick = '0;
        st_report_tick = '0;
        st_now = '0;
        st_bitrate = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_interval(32'd1);
        push_event(rand_fields(rrs_pkg::REQ_KEYFRAME));
        push_event(rand_fields(rrs_pkg::REQ_TICK));
        ev = rand_fields(rrs_pkg::REQ_RR);
        ev.ssrc = 32'h0;
        push_event(ev);
        ev = rand_fields(rrs_pkg::REQ_SR);
        ev.ntp = 64'h0;
        push_event(ev);
        ev = rand_fields(rrs_pkg::REQ_BITRATE);
        ev.rate = 32'hFFFF_FFFF;
        push_event(ev);
        ev = rand_fields(rrs_pkg::REQ_SR);
        ev.ntp = '1;
        push_event(ev);
        ev = rand_fields(rrs_pkg::REQ_BITRATE);
        ev.rate = 32'd0;
        push_event(ev);
        ev = good_rtp($urandom, 16'($urandom));
        ev.too_short = 1'b1;
        push_event(ev);
        ev = good_rtp($urandom, 16'($urandom));
        ev.ver = 2'd0;
        push_event(ev);
        ev = good_rtp($urandom, 16'($urandom));
        ev.ver = 2'd3;
        push_event(ev);
        ev = good_rtp($urandom, 16'($urandom));
        ev.pt = rrs_pkg::PT_SR_MUXED;
        push_event(ev);
        ev = good_rtp($urandom, 16'($urandom));
        ev.pt = rrs_pkg::PT_RR_MUXED;
        push_event(ev);
        ev = good_rtp(32'hFFFF_FFFF, 16'hFFFF);
        ev.pt = 8'hFF;
        push_event(ev);
        ev = good_rtp(32'h0, 16'h0000);
        ev.pt = 8'h00;
        push_event(ev);
        push_event(good_rtp(gen_ssrc, 16'd0));
        push_event(rand_fields(rrs_pkg::REQ_TICK));
        push_event(good_rtp(gen_ssrc, 16'd5));
        push_event(good_rtp(gen_ssrc, 16'd2));
        push_event(rand_fields(rrs_pkg::REQ_TICK));
        push_event(good_rtp(gen_ssrc, 16'd32773));
        push_event(good_rtp(gen_ssrc, 16'd4));
        push_event(good_rtp(gen_ssrc, 16'd32772));
        push_event(good_rtp(gen_ssrc, 16'd4));
        push_event(rand_fields(rrs_pkg::REQ_TICK));
        push_event(rand_fields(3'd6));
        push_event(rand_fields(3'd7));
        wait_drained;
        gen_seq = 16'd32772;

        run_phase(32'd2,           0,  0, 200, 1'b0, 1'b0);
        run_phase(32'd1,          54,  0, 200, 1'b0, 1'b0);
        run_phase(32'hFFFF_FFFF,   0, 54, 150, 1'b0, 1'b0);
        run_phase(32'd5,          31, 31, 200, 1'b0, 1'b0);
        run_phase(32'd3,           0,  0, 200, 1'b0, 1'b1);
        run_phase(32'd1,          31, 31, 600, 1'b1, 1'b0);
        run_phase(32'd17,          0, 54, 200, 1'b0, 1'b0);

        repeat (20) @(posedge clk);
        if (predicted_results.size() != 0)
        begin
            $display("%0d expected output words never arrived", predicted_results.size());
            fail_count += predicted_results.size();
        end
        $display("Covered %0d events over %0d random phases: %0d forwards, %0d REMBs, %0d PLIs.",
                 items_accepted, phase_count, kind_seen[rrs_pkg::KIND_FWD],
                 kind_seen[rrs_pkg::KIND_REMB], kind_seen[rrs_pkg::KIND_PLI]);
        $display("Receiver reports: %0d, silent words: %0d, mismatches: %0d.",
                 kind_seen[rrs_pkg::KIND_REPORT], kind_seen[rrs_pkg::KIND_NONE], fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("Timeout with %0d of %0d events accepted", items_accepted, items_pushed);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rrs_pkg.sv
rtl/rrs_ctrl.sv
rtl/rrs_datapath.sv
rtl/rtp_receiver_statistics.sv
rtl/rrs_checker.sv
sim/rtp_receiver_statistics_tb.sv
